[hw/rtl/swagg_pkg.sv]
// Shared types, codes and the control store of the sliding window aggregate.
package swagg_pkg;

  localparam int DATA_W  = 32;
  localparam int WS_W    = 7;
  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 4;
  localparam int CDATA_W = 7;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE = 4'd0;
  localparam logic [CIDX_W-1:0] REG_MODE        = 4'd1;

  // Aggregate modes
  localparam logic [MODE_W-1:0] MODE_AVG = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUM = 3'd4;

  // Program steps
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_DRAIN,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_RESULT,
    ST_STORE
  } step_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_SKIP,
    C_MORE,
    C_NOT_AVG,
    C_DIV_BUSY,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    logic  clr;
    logic  rd;
    logic  acc;
    logic  div_go;
    logic  load_out;
    logic  store;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic skip;
    logic more;
    logic not_avg;
    logic div_busy;
    logic out_blocked;
  } status_t;

  function automatic ucode_t swagg_ucode(input step_t s);
    ucode_t w;
    w        = '0;
    w.cond   = C_ALWAYS;
    w.target = ST_IDLE;
    case (s)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.clr    = 1'b1;
        w.cond   = C_NO_INPUT;
        w.target = ST_IDLE;
      end
      ST_CHECK: begin
        w.cond   = C_SKIP;
        w.target = ST_RESULT;
      end
      ST_LOOP: begin
        w.rd     = 1'b1;
        w.acc    = 1'b1;
        w.cond   = C_MORE;
        w.target = ST_LOOP;
      end
      ST_DRAIN: begin
        w.acc    = 1'b1;
        w.cond   = C_NOT_AVG;
        w.target = ST_RESULT;
      end
      ST_DIVGO: begin
        w.div_go = 1'b1;
        w.cond   = C_NOT_AVG;
        w.target = ST_RESULT;
      end
      ST_DIVWAIT: begin
        w.cond   = C_DIV_BUSY;
        w.target = ST_DIVWAIT;
      end
      ST_RESULT: begin
        w.load_out = 1'b1;
        w.cond     = C_OUT_BLOCKED;
        w.target   = ST_RESULT;
      end
      ST_STORE: begin
        w.store  = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/swagg_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module swagg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  swagg_pkg::status_t status,
  output swagg_pkg::ucode_t  ctrl
);

  swagg_pkg::step_t pc_r;
  swagg_pkg::step_t pc_nxt;
  logic             take;

  // Control word of the current step
  always_comb begin
    ctrl = swagg_pkg::swagg_ucode(pc_r);
  end

  // Next step: jump when the condition holds, else fall through
  always_comb begin
    case (ctrl.cond)
      swagg_pkg::C_ALWAYS:      take = 1'b1;
      swagg_pkg::C_NO_INPUT:    take = !status.in_valid;
      swagg_pkg::C_SKIP:        take = status.skip;
      swagg_pkg::C_MORE:        take = status.more;
      swagg_pkg::C_NOT_AVG:     take = status.not_avg;
      swagg_pkg::C_DIV_BUSY:    take = status.div_busy;
      swagg_pkg::C_OUT_BLOCKED: take = status.out_blocked;
      default:                  take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : swagg_pkg::step_t'(pc_r + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= swagg_pkg::ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[hw/rtl/swagg_div.sv]
// Restoring divider: signed dividend by unsigned count, one quotient bit a cycle.
module swagg_div #(
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [swagg_pkg::DATA_W-1:0] dividend,
  input  logic [CNT_W-1:0]                    divisor,
  output logic                                busy,
  output logic signed [swagg_pkg::DATA_W-1:0] quotient
);

  localparam int DW  = swagg_pkg::DATA_W;
  localparam int BCW = $clog2(DW);

  logic [DW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [BCW-1:0]   bit_r, bit_nxt;
  logic             busy_r, busy_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W:0]   trial;
  logic [DW-1:0]    mag;

  always_comb begin
    mag      = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
    trial    = {rem_r, q_r[DW-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    if (start) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      bit_nxt  = BCW'(DW - 1);
      busy_nxt = 1'b1;
      neg_nxt  = dividend[DW-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CNT_W'(trial - {1'b0, divisor});
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      if (bit_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        bit_nxt = bit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

[hw/rtl/sliding_window_aggregate.sv]
// Sliding window aggregate (average, maximum, minimum, sum) over previous samples.
//
// Each transaction on the input channel carries one signed 32-bit sample and
// produces exactly one aggregate on the output channel. The aggregate covers
// the last min(window_size, samples seen) samples before the current one; the
// very first result, and any result in an unknown mode, is zero. Sums wrap at
// 32 bits and the average truncates toward zero. A microcoded sequencer runs
// each item: the stored samples are streamed out of the sample memory at one
// entry a cycle and folded, and in average mode the serial divider then adds
// one quotient bit a cycle. An item with no previous sample, or an unknown
// mode, skips the scan and the divider. One item is worked at a time; the
// finished aggregate sits in an output register, so the next sample is taken
// while it waits. The sample memory needs no clearing after reset: entries
// are read only after written. Write window_size (register 0) and mode
// (register 1) only while idle; window_size 0 acts as 1 and values above
// MAX_WINDOW saturate.
module sliding_window_aggregate #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [swagg_pkg::DATA_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [swagg_pkg::DATA_W-1:0]  out_aggregate,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swagg_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [swagg_pkg::CDATA_W-1:0]        cfg_data
);

  localparam int DW = swagg_pkg::DATA_W;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = $clog2(MAX_WINDOW);

  swagg_pkg::ucode_t  ctrl;
  swagg_pkg::status_t status;

  // Configuration registers
  logic [swagg_pkg::WS_W-1:0]   win_size_r;
  logic [swagg_pkg::MODE_W-1:0] mode_r;

  // Item datapath
  logic signed [DW-1:0] sample_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        raddr_r, raddr_nxt;
  logic                 rvld_r, rvld_nxt;
  logic                 first_r, first_nxt;
  logic signed [DW-1:0] sum_r, sum_nxt;
  logic signed [DW-1:0] best_r, best_nxt;
  logic signed [DW-1:0] rd_data_r;

  // Window bookkeeping
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0] slot;
  logic [AW-1:0] waddr;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_agg_r, out_agg_nxt;

  logic                 in_fire;
  logic                 mode_ok;
  logic [CW-1:0]        ws_eff;
  logic                 div_busy;
  logic signed [DW-1:0] quot;
  logic signed [DW-1:0] result;

  logic signed [DW-1:0] window_mem_r [MAX_WINDOW];

  swagg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  swagg_div #(
    .CNT_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_go),
    .dividend (sum_r),
    .divisor  (count_r),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign in_ready  = ctrl.in_rdy;
  assign in_fire   = in_valid && ctrl.in_rdy;
  assign cfg_ready = 1'b1;

  // Effective window: zero acts as one, saturate at the store depth
  always_comb begin
    if (win_size_r == '0) begin
      ws_eff = CW'(1);
    end else if (32'(win_size_r) > 32'(MAX_WINDOW)) begin
      ws_eff = CW'(MAX_WINDOW);
    end else begin
      ws_eff = CW'(win_size_r);
    end
  end

  assign mode_ok = (mode_r == swagg_pkg::MODE_AVG) || (mode_r == swagg_pkg::MODE_MAX) ||
                   (mode_r == swagg_pkg::MODE_MIN) || (mode_r == swagg_pkg::MODE_SUM);

  // Status seen by the sequencer's jump conditions
  always_comb begin
    status.in_valid    = in_valid;
    status.skip        = (count_r == '0) || !mode_ok;
    status.more        = (raddr_r + CW'(1)) < count_r;
    status.not_avg     = (mode_r != swagg_pkg::MODE_AVG);
    status.div_busy    = div_busy;
    status.out_blocked = out_valid_r && !out_ready;
  end

  // Scan: issue one read a cycle, fold the data once the registered read port returns it
  always_comb begin
    count_nxt = count_r;
    raddr_nxt = raddr_r;
    rvld_nxt  = 1'b0;
    first_nxt = first_r;
    sum_nxt   = sum_r;
    best_nxt  = best_r;
    if (in_fire) begin
      count_nxt = (fill_r < ws_eff) ? fill_r : ws_eff;
    end
    if (ctrl.clr) begin
      raddr_nxt = '0;
      first_nxt = 1'b1;
      sum_nxt   = '0;
    end
    if (ctrl.rd) begin
      raddr_nxt = raddr_r + CW'(1);
      rvld_nxt  = 1'b1;
    end
    if (ctrl.acc && rvld_r) begin
      sum_nxt = sum_r + rd_data_r;
      if (first_r) begin
        best_nxt  = rd_data_r;
        first_nxt = 1'b0;
      end else if ((mode_r == swagg_pkg::MODE_MAX) && (rd_data_r > best_r)) begin
        best_nxt = rd_data_r;
      end else if ((mode_r == swagg_pkg::MODE_MIN) && (rd_data_r < best_r)) begin
        best_nxt = rd_data_r;
      end
    end
  end

  // Pick the aggregate for the current mode
  always_comb begin
    if (status.skip) begin
      result = '0;
    end else if (mode_r == swagg_pkg::MODE_AVG) begin
      result = quot;
    end else if (mode_r == swagg_pkg::MODE_SUM) begin
      result = sum_r;
    end else begin
      result = best_r;
    end
  end

  // Hold the result until taken; load only into a free or draining register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_agg_nxt   = out_agg_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.load_out && !status.out_blocked) begin
      out_valid_nxt = 1'b1;
      out_agg_nxt   = result;
    end
  end

  // Store the sample: fill order first, then replace the oldest in ring order
  always_comb begin
    fill_nxt   = fill_r;
    oldest_nxt = oldest_r;
    slot       = (CW'(oldest_r) >= ws_eff) ? '0 : oldest_r;
    if (fill_r >= ws_eff) begin
      waddr = slot;
    end else begin
      waddr = fill_r[AW-1:0];
    end
    if (ctrl.store) begin
      if (fill_r >= ws_eff) begin
        oldest_nxt = ((CW'(slot) + CW'(1)) == ws_eff) ? '0 : (slot + AW'(1));
      end
      if (fill_r < CW'(MAX_WINDOW)) begin
        fill_nxt = fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r  <= swagg_pkg::WS_W'(1);
      mode_r      <= '0;
      count_r     <= '0;
      raddr_r     <= '0;
      rvld_r      <= 1'b0;
      first_r     <= 1'b1;
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == swagg_pkg::REG_WINDOW_SIZE)) begin
        win_size_r <= cfg_data[swagg_pkg::WS_W-1:0];
      end
      if (cfg_valid && (cfg_index == swagg_pkg::REG_MODE)) begin
        mode_r <= cfg_data[swagg_pkg::MODE_W-1:0];
      end
      count_r     <= count_nxt;
      raddr_r     <= raddr_nxt;
      rvld_r      <= rvld_nxt;
      first_r     <= first_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_sample;
    end
    sum_r     <= sum_nxt;
    best_r    <= best_nxt;
    out_agg_r <= out_agg_nxt;
  end

  // Sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      window_mem_r[waddr] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= window_mem_r[raddr_r[AW-1:0]];
  end

  assign out_valid     = out_valid_r;
  assign out_aggregate = out_agg_r;

endmodule

[hw/rtl/swagg_chk.sv]
// Port checker for the sliding window aggregate, bound to the top level.
module swagg_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [swagg_pkg::DATA_W-1:0] out_aggregate
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_aggregate))
    else $error("stalled result changed");

  // One item at a time: the input closes after each transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input open straight after a transaction");

  // A new result appears only while an item is being worked
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no item in flight");

endmodule

bind sliding_window_aggregate swagg_chk u_swagg_chk (.*);
